// ===== sv/bfmm_pkg.sv =====
package bfmm_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] c_value;
        logic [2:0]  c_row;
        logic [5:0]  c_col;
    } t_out_item;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_BELEM = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic a_wr;
        logic rd_ab;
        logic mul;
        logic rnd1;
        logic rnd2_prod;
        logic align;
        logic acc_wr;
        logic rd_c;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       ld_ok;
        logic       b_ok;
        logic       rd_ok;
        logic       out_busy;
    } t_stat;

    localparam logic [31:0] FP32_INF   = 32'h7F80_0000;
    localparam logic [30:0] FP32_QNAN  = 31'h7FC0_0000;

    // leading zeros of a 28 bit word, 28 for zero
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) begin
                n = 5'(27 - i);
            end
        end
        return n;
    endfunction

    // fp32 to bf16, rounding toward negative infinity, NaN made quiet
    function automatic logic [15:0] fp32_to_bf16_floor(input logic [31:0] f);
        logic [15:0] hi;
        hi = f[31:16];
        if (f[30:23] == 8'hFF && f[22:0] != 23'd0) begin
            hi = {f[31], 15'h7FC0};
        end else if (f[31] && f[15:0] != 16'd0) begin
            hi = hi + 16'd1;
        end
        return hi;
    endfunction

endpackage

// ===== sv/bfmm_ram.sv =====
module bfmm_ram
    import bfmm_pkg::*;
#(
    parameter int W = 16,
    parameter int D = 512
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bfmm_ctrl.sv =====
module bfmm_ctrl
    import bfmm_pkg::*;
#(
    parameter int ROWS_M = 8,
    parameter int COLS_N = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  t_stat                              i_st,
    output t_cmd                               o_cmd,
    output logic [$clog2(ROWS_M*COLS_N)-1:0]   o_idx
);
    localparam int CW = $clog2(ROWS_M*COLS_N);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_R1   = 4'd5;
    localparam logic [3:0] S_R2   = 4'd6;
    localparam logic [3:0] S_ALN  = 4'd7;
    localparam logic [3:0] S_R1B  = 4'd8;
    localparam logic [3:0] S_R2B  = 4'd9;
    localparam logic [3:0] S_RDC  = 4'd10;
    localparam logic [3:0] S_RDW  = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx   = '0;
                n_state = S_IDLE;
                case (i_st.opcode)
                    OP_CLEAR: n_state = S_CLR;
                    OP_LOAD:  o_cmd.a_wr = i_st.ld_ok;
                    OP_BELEM: if (i_st.b_ok) n_state = S_RD;
                    OP_READ:  if (i_st.rd_ok) n_state = S_RDC;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(ROWS_M*COLS_N-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd_ab = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_R1;
            end
            S_R1: begin
                o_cmd.rnd1 = 1'b1;
                n_state = S_R2;
            end
            S_R2: begin
                o_cmd.rnd2_prod = 1'b1;
                n_state = S_ALN;
            end
            S_ALN: begin
                o_cmd.align = 1'b1;
                n_state = S_R1B;
            end
            S_R1B: begin
                o_cmd.rnd1 = 1'b1;
                n_state = S_R2B;
            end
            S_R2B: begin
                o_cmd.acc_wr = 1'b1;
                n_idx = r_idx + CW'(1);
                n_state = (r_idx == CW'(ROWS_M-1)) ? S_IDLE : S_RD;
            end
            S_RDC: begin
                o_cmd.rd_c = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_idx   = r_idx;

    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DISP))
        else $error("accepted item not dispatched");
    a_mac_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R2B) |=> (r_state == S_RD || r_state == S_IDLE))
        else $error("row loop left its sequence");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("result loaded without returning to idle");
endmodule

// ===== sv/bfmm_dp.sv =====
module bfmm_dp
    import bfmm_pkg::*;
#(
    parameter int ROWS_M  = 8,
    parameter int INNER_K = 64,
    parameter int COLS_N  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_in_item                           i_item,
    input  t_cmd                               i_cmd,
    input  logic [$clog2(ROWS_M*COLS_N)-1:0]   i_idx,
    output t_stat                              o_st,
    output logic                               o_valid,
    input  logic                               i_stall,
    output t_out_item                          o_item
);
    localparam int AAW = $clog2(ROWS_M*INNER_K);
    localparam int CAW = $clog2(ROWS_M*COLS_N);

    t_in_item    r_item;
    logic [31:0] r_prod;
    logic        r_out_valid;
    t_out_item   r_out_item;

    // rounder input stage
    logic [27:0]        r_rm;
    logic signed [11:0] r_rx;
    logic               r_rs, r_rspec;
    logic [31:0]        r_rspec_bits;
    // rounder normalised stage
    logic [27:0]        r_nm;
    logic signed [11:0] r_ne;
    logic               r_nz, r_ns, r_nspec;
    logic [31:0]        r_nspec_bits;

    logic [15:0] a_rdata;
    logic [31:0] c_rdata;

    // ---- address generation ----
    logic [AAW-1:0] a_waddr, a_raddr;
    logic [CAW-1:0] c_waddr, c_raddr, c_m_addr;

    assign a_waddr  = AAW'(AAW'(r_item.row) * AAW'(INNER_K) + AAW'(r_item.col));
    assign a_raddr  = AAW'(AAW'(i_idx) * AAW'(INNER_K) + AAW'(r_item.row));
    assign c_m_addr = CAW'(i_idx * CAW'(COLS_N) + CAW'(r_item.col));
    assign c_waddr  = i_cmd.clr_wr ? i_idx : c_m_addr;
    assign c_raddr  = i_cmd.rd_c ? CAW'(CAW'(r_item.row) * CAW'(COLS_N) + CAW'(r_item.col))
                                 : c_m_addr;

    // ---- multiply: exact bf16 product ----
    logic [7:0]         ma, mb;
    logic [8:0]         ea, eb;
    logic               sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [15:0]        pm;
    logic               m_spec;
    logic [31:0]        m_spec_bits;

    always_comb begin
        sa     = a_rdata[15];
        sb     = r_item.value[15];
        ma     = {a_rdata[14:7] != 8'd0, a_rdata[6:0]};
        mb     = {r_item.value[14:7] != 8'd0, r_item.value[6:0]};
        ea     = (a_rdata[14:7] == 8'd0) ? 9'd1 : {1'b0, a_rdata[14:7]};
        eb     = (r_item.value[14:7] == 8'd0) ? 9'd1 : {1'b0, r_item.value[14:7]};
        a_nan  = (a_rdata[14:7] == 8'hFF) && (a_rdata[6:0] != 7'd0);
        b_nan  = (r_item.value[14:7] == 8'hFF) && (r_item.value[6:0] != 7'd0);
        a_inf  = (a_rdata[14:7] == 8'hFF) && (a_rdata[6:0] == 7'd0);
        b_inf  = (r_item.value[14:7] == 8'hFF) && (r_item.value[6:0] == 7'd0);
        a_zero = (a_rdata[14:0] == 15'd0);
        b_zero = (r_item.value[14:0] == 15'd0);
        pm     = ma * mb;
        m_spec = a_nan || b_nan || a_inf || b_inf;
        if (a_nan) begin
            m_spec_bits = {sa, FP32_QNAN};
        end else if (b_nan) begin
            m_spec_bits = {sb, FP32_QNAN};
        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            m_spec_bits = {1'b1, FP32_QNAN};
        end else begin
            m_spec_bits = {sa ^ sb, FP32_INF[30:0]};
        end
    end

    // ---- align and add accumulator with product ----
    logic [23:0]        mA, mP, mbig, msml;
    logic [8:0]         eA, eP, ebig, esml, dexp;
    logic               sA, sP, sbig, A_nan, P_nan, A_inf, P_inf, a_big;
    logic [26:0]        sx, sshift, lost;
    logic [4:0]         dsh;
    logic [27:0]        bigx, sml_f, ssum;
    logic               s_spec;
    logic [31:0]        s_spec_bits;

    always_comb begin
        sA    = c_rdata[31];
        sP    = r_prod[31];
        mA    = {c_rdata[30:23] != 8'd0, c_rdata[22:0]};
        mP    = {r_prod[30:23] != 8'd0, r_prod[22:0]};
        eA    = (c_rdata[30:23] == 8'd0) ? 9'd1 : {1'b0, c_rdata[30:23]};
        eP    = (r_prod[30:23] == 8'd0) ? 9'd1 : {1'b0, r_prod[30:23]};
        A_nan = (c_rdata[30:23] == 8'hFF) && (c_rdata[22:0] != 23'd0);
        P_nan = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] != 23'd0);
        A_inf = (c_rdata[30:23] == 8'hFF) && (c_rdata[22:0] == 23'd0);
        P_inf = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] == 23'd0);
        a_big = (c_rdata[30:0] >= r_prod[30:0]);
        mbig  = a_big ? mA : mP;
        msml  = a_big ? mP : mA;
        ebig  = a_big ? eA : eP;
        esml  = a_big ? eP : eA;
        sbig  = a_big ? sA : sP;
        dexp  = ebig - esml;
        dsh   = (dexp > 9'd27) ? 5'd28 : dexp[4:0];
        sx    = {msml, 3'b000};
        sshift = sx >> dsh;
        lost  = sx & ~({27{1'b1}} << dsh);
        sml_f = {1'b0, sshift[26:1], sshift[0] | (lost != 27'd0)};
        bigx  = {1'b0, mbig, 3'b000};
        ssum  = (sA == sP) ? (bigx + sml_f) : (bigx - sml_f);
        s_spec = A_nan || P_nan || A_inf || P_inf;
        if (A_nan) begin
            s_spec_bits = {sA, FP32_QNAN};
        end else if (P_nan) begin
            s_spec_bits = {sP, FP32_QNAN};
        end else if (A_inf && P_inf && (sA != sP)) begin
            s_spec_bits = {1'b1, FP32_QNAN};
        end else if (A_inf) begin
            s_spec_bits = c_rdata;
        end else begin
            s_spec_bits = r_prod;
        end
    end

    // ---- round to fp32, nearest even ----
    logic [4:0]   lz;
    logic [4:0]   rsh;
    logic [27:0]  rsv, rlost;
    logic [23:0]  rmant;
    logic         rg, rst_b, rinc;
    logic [24:0]  rm25;
    logic [7:0]   rbase;
    logic [31:0]  rsum;
    logic [31:0]  res32;
    logic signed [11:0] rneg;

    assign lz = lzc28(r_rm);

    always_comb begin
        rneg  = 12'sd1 - r_ne;
        rsh   = (r_ne >= 12'sd1) ? 5'd0 : ((rneg > 12'sd28) ? 5'd28 : rneg[4:0]);
        rsv   = r_nm >> rsh;
        rlost = r_nm & ~({28{1'b1}} << rsh);
        rmant = rsv[27:4];
        rg    = rsv[3];
        rst_b = (rsv[2:0] != 3'd0) || (rlost != 28'd0);
        rinc  = rg && (rst_b || rmant[0]);
        rm25  = {1'b0, rmant} + 25'(rinc);
        rbase = (r_ne >= 12'sd1) ? 8'(r_ne - 12'sd1) : 8'd0;
        rsum  = {1'b0, rbase, 23'd0} + 32'(rm25);
        if (r_nspec) begin
            res32 = r_nspec_bits;
        end else if (r_nz) begin
            res32 = {r_ns, 31'd0};
        end else if (r_ne > 12'sd254 || rsum >= FP32_INF) begin
            res32 = {r_ns, FP32_INF[30:0]};
        end else begin
            res32 = {r_ns, rsum[30:0]};
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.mul) begin
            r_rm         <= {12'd0, pm};
            r_rx         <= 12'(signed'({3'b000, ea})) + 12'(signed'({3'b000, eb})) - 12'sd268;
            r_rs         <= sa ^ sb;
            r_rspec      <= m_spec;
            r_rspec_bits <= m_spec_bits;
        end
        if (i_cmd.align) begin
            r_rm         <= ssum;
            r_rx         <= 12'(signed'({3'b000, ebig})) - 12'sd153;
            r_rs         <= (ssum == 28'd0) ? (sA & sP) : sbig;
            r_rspec      <= s_spec;
            r_rspec_bits <= s_spec_bits;
        end
        if (i_cmd.rnd1) begin
            r_nm         <= r_rm << lz;
            r_ne         <= r_rx + 12'sd154 - 12'(signed'({7'd0, lz}));
            r_nz         <= (r_rm == 28'd0);
            r_ns         <= r_rs;
            r_nspec      <= r_rspec;
            r_nspec_bits <= r_rspec_bits;
        end
        if (i_cmd.rnd2_prod) begin
            r_prod <= res32;
        end
        if (i_cmd.out_load) begin
            r_out_item.c_value <= fp32_to_bf16_floor(c_rdata);
            r_out_item.c_row   <= r_item.row[2:0];
            r_out_item.c_col   <= r_item.col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    bfmm_ram #(.W(16), .D(ROWS_M*INNER_K)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.a_wr),
        .i_waddr (a_waddr),
        .i_wdata (r_item.value),
        .i_re    (i_cmd.rd_ab),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    bfmm_ram #(.W(32), .D(ROWS_M*COLS_N)) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr | i_cmd.acc_wr),
        .i_waddr (c_waddr),
        .i_wdata (i_cmd.clr_wr ? 32'd0 : res32),
        .i_re    (i_cmd.rd_ab | i_cmd.rd_c),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign o_st.opcode   = r_item.opcode;
    assign o_st.ld_ok    = (10'(r_item.row) < 10'(ROWS_M)) && (10'(r_item.col) < 10'(INNER_K));
    assign o_st.b_ok     = (10'(r_item.row) < 10'(INNER_K)) && (10'(r_item.col) < 10'(COLS_N));
    assign o_st.rd_ok    = (10'(r_item.row) < 10'(ROWS_M)) && (10'(r_item.col) < 10'(COLS_N));
    assign o_st.out_busy = r_out_valid && i_stall;

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;
endmodule

// ===== sv/bf16_matrix_multiply_tile_top.sv =====
// bf16 matrix multiply tile: C = A x B with A of ROWS_M x INNER_K and B of
// INNER_K x COLS_N, all bf16, one fp32 accumulator per C element. Items carry
// an opcode: clear zeroes every accumulator, load A writes one A element,
// B element k,n adds A[m][k]*B[k][n] to accumulator (m,n) for every row m
// (product rounded once to fp32, then an fp32 add, both nearest even), and
// read C returns accumulator (m,n) rounded to bf16 toward negative infinity
// (NaN comes back as a quiet NaN with its sign). Out-of-range items are
// dropped; only an in-range read yields a result item. One item is worked on
// at a time: a read waits while the result register is still held, a B
// element goes through the single shared multiply, align/add and rounding
// unit once for each row, stepping through the rows, and a clear makes one
// accumulator memory write per cycle. After reset the same clearing pass
// runs before the first item is taken. The result register frees the output
// side, so a waiting result holds back only the next read; loads, B elements
// and clears go on.
module bf16_matrix_multiply_tile_top
    import bfmm_pkg::*;
#(
    parameter int ROWS_M  = 8,
    parameter int INNER_K = 64,
    parameter int COLS_N  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_cmd  cmd;
    t_stat st;
    logic [$clog2(ROWS_M*COLS_N)-1:0] idx;

    // sequence the work: dispatch, row loop, clearing sweep
    bfmm_ctrl #(.ROWS_M(ROWS_M), .COLS_N(COLS_N)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    // hold the memories, the fp arithmetic and the result register
    bfmm_dp #(.ROWS_M(ROWS_M), .INNER_K(INNER_K), .COLS_N(COLS_N)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_idx   (idx),
        .o_st    (st),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );
endmodule
